// ===== rtl/ulf_pkg.sv =====
// ----------------------------------------------------------------------------
// ulf_pkg: shared types and functions of the UTF-8 Latin folding block
// Holds the open-sequence state, the letter group types, the lead byte
// classifier and the code point to plain letter table.
// ----------------------------------------------------------------------------
package ulf_pkg;

    localparam int unsigned LetterW = 7;
    localparam int unsigned MaxLetters = 4;
    localparam int unsigned CodeW = 21;

    typedef struct packed {
        logic [7:0]  lead;
        logic        valid;
        logic [1:0]  seen;
        logic [17:0] accum;
    } t_seq;

    typedef struct packed {
        logic [1:0]         count;
        logic [LetterW-1:0] first;
        logic [LetterW-1:0] second;
    } t_fold;

    typedef logic [LetterW-1:0] t_letter;

    typedef struct packed {
        logic [2:0] count;
        t_letter [MaxLetters-1:0] slot;
    } t_group;

    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b[7:5] == 3'b110) begin
            n = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            n = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic t_fold one(input logic [7:0] c);
        t_fold r;
        r.count  = 2'd1;
        r.first  = c[6:0];
        r.second = '0;
        return r;
    endfunction

    function automatic t_fold two(input logic [7:0] c1, input logic [7:0] c2);
        t_fold r;
        r.count  = 2'd2;
        r.first  = c1[6:0];
        r.second = c2[6:0];
        return r;
    endfunction

    // Maps one code point to zero, one or two plain letters.
    function automatic t_fold fold_code(input logic [CodeW-1:0] code);
        t_fold r;
        logic [6:0] c;
        r = '0;
        c = code[6:0];
        if (code < CodeW'(9'h080)) begin
            if ((c >= 7'h30 && c <= 7'h39) || (c >= 7'h61 && c <= 7'h7A)) begin
                r = one({1'b0, c});
            end else if (c >= 7'h41 && c <= 7'h5A) begin
                r = one({1'b0, c | 7'h20});
            end
        end else if (code < CodeW'(9'h180)) begin
            case (code[8:0]) inside
                [9'h0C0:9'h0C5]: r = one("a");
                9'h0C6:          r = two("a", "e");
                9'h0C7:          r = one("c");
                [9'h0C8:9'h0CB]: r = one("e");
                [9'h0CC:9'h0CF]: r = one("i");
                9'h0D0:          r = one("d");
                9'h0D1:          r = one("n");
                [9'h0D2:9'h0D6]: r = one("o");
                9'h0D8:          r = one("o");
                [9'h0D9:9'h0DC]: r = one("u");
                9'h0DD:          r = one("y");
                9'h0DF:          r = two("s", "s");
                [9'h0E0:9'h0E5]: r = one("a");
                9'h0E6:          r = two("a", "e");
                9'h0E7:          r = one("c");
                [9'h0E8:9'h0EB]: r = one("e");
                [9'h0EC:9'h0EF]: r = one("i");
                9'h0F0:          r = one("d");
                9'h0F1:          r = one("n");
                [9'h0F2:9'h0F6]: r = one("o");
                9'h0F8:          r = one("o");
                [9'h0F9:9'h0FC]: r = one("u");
                9'h0FD:          r = one("y");
                9'h0FF:          r = one("y");
                [9'h100:9'h105]: r = one("a");
                [9'h106:9'h10D]: r = one("c");
                [9'h10E:9'h111]: r = one("d");
                [9'h112:9'h11B]: r = one("e");
                [9'h11C:9'h123]: r = one("g");
                [9'h124:9'h127]: r = one("h");
                [9'h128:9'h131]: r = one("i");
                [9'h132:9'h133]: r = two("i", "j");
                [9'h134:9'h135]: r = one("j");
                [9'h136:9'h138]: r = one("k");
                [9'h139:9'h142]: r = one("l");
                [9'h143:9'h14B]: r = one("n");
                [9'h14C:9'h151]: r = one("o");
                [9'h152:9'h153]: r = two("o", "e");
                [9'h154:9'h159]: r = one("r");
                [9'h15A:9'h161]: r = one("s");
                [9'h162:9'h167]: r = one("t");
                [9'h168:9'h173]: r = one("u");
                [9'h174:9'h175]: r = one("w");
                [9'h176:9'h178]: r = one("y");
                [9'h179:9'h17E]: r = one("z");
                9'h17F:          r = one("s");
                default:         r = '0;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== rtl/ulf_decode.sv =====
// ----------------------------------------------------------------------------
// ulf_decode: one step of the UTF-8 decoder and letter folder
// From the open-sequence state and one text byte, computes the next state
// and the group of up to four letters that the byte releases.
// ----------------------------------------------------------------------------
module ulf_decode
    import ulf_pkg::*;
(
    input  t_seq       i_seq,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output t_seq       o_seq,
    output t_group     o_group
);

    logic              is_cont;
    logic              fresh;
    logic [1:0]        need;
    logic [1:0]        seen_n;
    logic [17:0]       acc_n;
    logic [CodeW-1:0]  code;
    t_fold             fa;
    t_fold             fb;

    always_comb begin
        is_cont = (i_byte[7:6] == 2'b10);
        need    = lead_need(i_seq.lead);
        acc_n   = {i_seq.accum[11:0], i_byte[5:0]};
        seen_n  = i_seq.seen + 2'd1;
        code    = '0;
        fresh   = 1'b1;
        fa      = '0;
        fb      = '0;
        o_seq   = i_seq;

        if (i_seq.valid) begin
            if (is_cont) begin
                fresh       = 1'b0;
                o_seq.accum = acc_n;
                o_seq.seen  = seen_n;
                if (seen_n >= need) begin
                    case (need)
                        2'd1:    code = {10'd0, i_seq.lead[4:0], acc_n[5:0]};
                        2'd2:    code = {5'd0, i_seq.lead[3:0], acc_n[11:0]};
                        default: code = {i_seq.lead[2:0], acc_n};
                    endcase
                    o_seq = '0;
                    fa    = fold_code(code);
                end else if (i_eot) begin
                    o_seq = '0;
                    fa    = fold_code({13'd0, i_seq.lead});
                end
            end else begin
                o_seq = '0;
                fa    = fold_code({13'd0, i_seq.lead});
            end
        end

        if (fresh) begin
            if (lead_need(i_byte) != 2'd0 && !i_eot) begin
                o_seq.lead  = i_byte;
                o_seq.valid = 1'b1;
                o_seq.seen  = 2'd0;
                o_seq.accum = '0;
            end else begin
                fb = fold_code({13'd0, i_byte});
            end
        end
    end

    // The flushed lead's letters come first, then those of the new byte.
    always_comb begin
        o_group.count   = {1'b0, fa.count} + {1'b0, fb.count};
        o_group.slot[3] = fb.second;
        case (fa.count)
            2'd0: begin
                o_group.slot[0] = fb.first;
                o_group.slot[1] = fb.second;
                o_group.slot[2] = '0;
            end
            2'd1: begin
                o_group.slot[0] = fa.first;
                o_group.slot[1] = fb.first;
                o_group.slot[2] = fb.second;
            end
            default: begin
                o_group.slot[0] = fa.first;
                o_group.slot[1] = fa.second;
                o_group.slot[2] = fb.first;
            end
        endcase
    end

endmodule

// ===== rtl/utf8_latin_fold.sv =====
// ----------------------------------------------------------------------------
// utf8_latin_fold: UTF-8 text to a folded Latin search key
// Takes one text byte per beat on the input channel and gives one key
// letter per beat on the output channel, each marked with last_of_run and
// text_done. Both channels use valid and ready.
// A byte is held in an input register, then decoded and its letters
// loaded into a four-letter result register that drives the output.
// Throughput is one byte per cycle while each byte yields at most one
// letter and the receiver is ready. A byte that yields several letters
// holds the result register until its last letter is taken, one letter
// per output beat, and the input waits meanwhile; bytes that yield
// nothing pass at one per cycle.
// When the receiver stalls, the current letter holds, the result register
// keeps its group, and the input register fills and then drops ready.
// Reset clears the input register's valid flag, the result register's
// count and the open UTF-8 sequence; the block takes a byte in the first
// cycle after reset.
// ----------------------------------------------------------------------------
module utf8_latin_fold
    import ulf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [7:0]   i_text_byte,
    input  logic         i_end_of_text,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [6:0]   o_letter,
    output logic         o_last_of_run,
    output logic         o_text_done
);

    logic         r_in_valid;
    logic [7:0]   r_byte;
    logic         r_eot;
    t_seq         r_seq;
    t_seq         n_seq;
    t_group       n_group;
    logic [2:0]   r_cnt;
    logic [1:0]   r_idx;
    t_letter [MaxLetters-1:0] r_slot;
    logic         r_out_eot;
    logic         last;
    logic         can_load;
    logic         advance;

    ulf_decode u_decode (
        .i_seq   (r_seq),
        .i_byte  (r_byte),
        .i_eot   (r_eot),
        .o_seq   (n_seq),
        .o_group (n_group)
    );

    assign last       = ({1'b0, r_idx} + 3'd1) == r_cnt;
    assign can_load   = (r_cnt == 3'd0) || (i_out_ready && last);
    assign advance    = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || can_load;

    assign o_out_valid   = (r_cnt != 3'd0);
    assign o_letter      = r_slot[r_idx];
    assign o_last_of_run = last;
    assign o_text_done   = r_out_eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_text_byte;
            r_eot  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (advance) begin
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (advance) begin
            r_cnt <= n_group.count;
            r_idx <= 2'd0;
        end else if (o_out_valid && i_out_ready) begin
            if (last) begin
                r_cnt <= 3'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_slot    <= n_group.slot;
            r_out_eot <= r_eot;
        end
    end

endmodule
